/* hdl/clws_pkg.sv */
package clws_pkg;

    // Request operation codes
    localparam logic [1:0] OP_WRITE_CMD  = 2'd0;
    localparam logic [1:0] OP_WRITE_CHAR = 2'd1;
    localparam logic [1:0] OP_SET_CURSOR = 2'd2;
    localparam logic [1:0] OP_TICK       = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FOUR_BIT_MODE = 2'd0;
    localparam logic [1:0] CFG_CURSOR_BASE   = 2'd1;
    localparam logic [1:0] CFG_PHASE_TICKS   = 2'd2;

    localparam int CFG_DATA_WIDTH = 16;

    // Configuration reset values
    localparam logic        FOUR_BIT_MODE_RST = 1'b1;
    localparam logic [7:0]  CURSOR_BASE_RST   = 8'h80;
    localparam logic [15:0] PHASE_TICKS_RST   = 16'd1;

    localparam int PHASE_COUNT_WIDTH_DEF = 16;

    // Row 0..3 start addresses of display memory
    localparam logic [7:0] ROW_OFFSET_0 = 8'h00;
    localparam logic [7:0] ROW_OFFSET_1 = 8'h40;
    localparam logic [7:0] ROW_OFFSET_2 = 8'h10;
    localparam logic [7:0] ROW_OFFSET_3 = 8'h50;

    localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] LOW_NIBBLE_MASK  = 8'h0F;

    // Item as seen by the sequencer
    typedef struct packed {
        logic       is_tick;
        logic       busy_line;
        logic       req_valid;
        logic [7:0] req_byte;
        logic       req_is_data;
    } item_t;

    // Settings used by the sequencer
    typedef struct packed {
        logic        four_bit_mode;
        logic [15:0] phase_ticks;
    } seq_cfg_t;

    // Line levels after an item
    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       e;
        logic [7:0] data;
        logic       drive;
        logic       idle;
    } lines_t;

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] off;
        case (row)
            2'd0:    off = ROW_OFFSET_0;
            2'd1:    off = ROW_OFFSET_1;
            2'd2:    off = ROW_OFFSET_2;
            2'd3:    off = ROW_OFFSET_3;
            default: off = ROW_OFFSET_0;
        endcase
        return off;
    endfunction

endpackage

/* hdl/clws_seq.sv */
module clws_seq #(
    parameter int PHASE_COUNT_WIDTH = clws_pkg::PHASE_COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  clws_pkg::item_t   item,
    input  clws_pkg::seq_cfg_t cfg,
    output clws_pkg::lines_t  lines_next,
    output logic              accepted
);

    localparam int CW = PHASE_COUNT_WIDTH;
    localparam int EW = (CW > 16) ? CW : 16;

    // Phase codes
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_BH1   = 4'd1;
    localparam logic [3:0] PH_BL1   = 4'd2;
    localparam logic [3:0] PH_BH2   = 4'd3;
    localparam logic [3:0] PH_BL2   = 4'd4;
    localparam logic [3:0] PH_WSET  = 4'd5;
    localparam logic [3:0] PH_WEH1  = 4'd6;
    localparam logic [3:0] PH_WHI   = 4'd7;
    localparam logic [3:0] PH_WEL1  = 4'd8;
    localparam logic [3:0] PH_WEH2  = 4'd9;
    localparam logic [3:0] PH_WLO   = 4'd10;
    localparam logic [3:0] PH_WFULL = 4'd11;
    localparam logic [3:0] PH_WEL2  = 4'd12;

    logic [3:0]    phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    pending_byte_reg, pending_byte_next;
    logic          pending_is_data_reg, pending_is_data_next;
    logic          busy_sample_reg, busy_sample_next;
    logic          rs_reg, rs_next;
    logic          rw_reg, rw_next;
    logic          e_reg, e_next;
    logic          drive_reg, drive_next;
    logic [7:0]    data_reg, data_next;

    logic [EW-1:0] ticks_ext;
    logic [EW-1:0] max_ext;
    logic [EW-1:0] target_ext;
    logic [CW-1:0] target;
    logic [CW-1:0] count_inc;
    logic          go;
    logic [3:0]    dest;

    // Phase length: zero reads as one, saturate to counter range
    always_comb begin
        ticks_ext  = EW'(cfg.phase_ticks);
        max_ext    = EW'({CW{1'b1}});
        target_ext = (ticks_ext > max_ext) ? max_ext : ticks_ext;
        target     = CW'(target_ext);
        if (target == '0) begin
            target = CW'(1);
        end
    end

    // Item handling and phase transitions
    always_comb begin
        phase_next           = phase_reg;
        count_next           = count_reg;
        pending_byte_next    = pending_byte_reg;
        pending_is_data_next = pending_is_data_reg;
        busy_sample_next     = busy_sample_reg;
        rs_next              = rs_reg;
        rw_next              = rw_reg;
        e_next               = e_reg;
        drive_next           = drive_reg;
        data_next            = data_reg;
        accepted             = 1'b0;
        go                   = 1'b0;
        dest                 = PH_IDLE;
        count_inc            = count_reg + CW'(1);

        if (step) begin
            if (item.is_tick) begin
                if (phase_reg != PH_IDLE) begin
                    if (phase_reg == PH_BH1 && count_reg == '0) begin
                        busy_sample_next = item.busy_line;
                    end
                    if (count_inc >= target) begin
                        go = 1'b1;
                        case (phase_reg)
                            PH_BH1: begin
                                if (cfg.four_bit_mode) begin
                                    dest = PH_BL1;
                                end else begin
                                    dest = busy_sample_next ? PH_BL2 : PH_WSET;
                                end
                            end
                            PH_BL1:   dest = PH_BH2;
                            PH_BH2:   dest = busy_sample_next ? PH_BL2 : PH_WSET;
                            PH_BL2:   dest = PH_BH1;
                            PH_WSET:  dest = PH_WEH1;
                            PH_WEH1:  dest = cfg.four_bit_mode ? PH_WHI : PH_WFULL;
                            PH_WHI:   dest = PH_WEL1;
                            PH_WEL1:  dest = PH_WEH2;
                            PH_WEH2:  dest = PH_WLO;
                            PH_WLO:   dest = PH_WEL2;
                            PH_WFULL: dest = PH_WEL2;
                            default:  dest = PH_IDLE;
                        endcase
                    end else begin
                        count_next = count_inc;
                    end
                end
            end else if (phase_reg == PH_IDLE && item.req_valid) begin
                pending_byte_next    = item.req_byte;
                pending_is_data_next = item.req_is_data;
                accepted             = 1'b1;
                go                   = 1'b1;
                dest                 = PH_BH1;
            end
        end

        // Line changes on entering a phase
        if (go) begin
            phase_next = dest;
            count_next = '0;
            case (dest)
                PH_BH1: begin
                    drive_next = 1'b0;
                    rs_next    = 1'b0;
                    rw_next    = 1'b1;
                    e_next     = 1'b1;
                end
                PH_BH2, PH_WEH1, PH_WEH2: e_next = 1'b1;
                PH_BL1, PH_BL2, PH_WEL1, PH_WEL2: e_next = 1'b0;
                PH_WSET: begin
                    drive_next = 1'b1;
                    rs_next    = pending_is_data_reg;
                    rw_next    = 1'b0;
                    e_next     = 1'b0;
                end
                PH_WHI:   data_next = (pending_byte_reg & clws_pkg::HIGH_NIBBLE_MASK) >> 4;
                PH_WLO:   data_next = pending_byte_reg & clws_pkg::LOW_NIBBLE_MASK;
                PH_WFULL: data_next = pending_byte_reg;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // Line levels after this item
    always_comb begin
        lines_next.rs    = rs_next;
        lines_next.rw    = rw_next;
        lines_next.e     = e_next;
        lines_next.drive = drive_next;
        lines_next.data  = drive_next ? data_next : 8'h00;
        lines_next.idle  = (phase_next == PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            count_reg           <= '0;
            pending_byte_reg    <= 8'h00;
            pending_is_data_reg <= 1'b0;
            busy_sample_reg     <= 1'b0;
            rs_reg              <= 1'b0;
            rw_reg              <= 1'b0;
            e_reg               <= 1'b0;
            drive_reg           <= 1'b0;
            data_reg            <= 8'h00;
        end else begin
            phase_reg           <= phase_next;
            count_reg           <= count_next;
            pending_byte_reg    <= pending_byte_next;
            pending_is_data_reg <= pending_is_data_next;
            busy_sample_reg     <= busy_sample_next;
            rs_reg              <= rs_next;
            rw_reg              <= rw_next;
            e_reg               <= e_next;
            drive_reg           <= drive_next;
            data_reg            <= data_next;
        end
    end

    // E is never left high between transfers
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> !e_reg)
        else $error("E high while idle");

    // During a transfer, reading and driving never coincide
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> drive_reg != rw_reg)
        else $error("RW and data drive disagree");

    // The phase counter rests at zero when idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> count_reg == '0)
        else $error("phase counter not cleared in idle");

    // A request is only taken from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accepted |-> phase_reg == PH_IDLE && phase_next == PH_BH1)
        else $error("request taken while busy");

endmodule

/* hdl/char_lcd_write_sequencer_core.sv */
// Character LCD write sequencer. Each transfer on the s_ channel is either a
// request (write command, write character, set cursor) or a tick that moves
// the busy-poll / write sequence on by one time step; every item yields one
// result on the m_ channel with the RS, RW, E and data line levels after it.
// One item is taken per clock: the phase state machine and the result
// register both update in the cycle the item is accepted, so its result is
// offered on the next cycle. While a result waits for m_ready, s_ready is
// low; a new item is taken in the same cycle the waiting result is taken, so
// items flow back to back whenever m_ready stays high. Settings on the cfg_
// port are to be written only while the block is idle; the block does not enforce this.
module char_lcd_write_sequencer_core #(
    parameter int PHASE_COUNT_WIDTH = clws_pkg::PHASE_COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_write_enable,
    input  logic [1:0]                          cfg_index,
    input  logic [clws_pkg::CFG_DATA_WIDTH-1:0] cfg_write_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic [7:0]                          s_value,
    input  logic [2:0]                          s_row,
    input  logic [7:0]                          s_column,
    input  logic                                s_busy_line,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_rs_line,
    output logic                                m_rw_line,
    output logic                                m_enable_line,
    output logic [7:0]                          m_data_lines,
    output logic                                m_data_drive,
    output logic                                m_idle,
    output logic                                m_accepted
);

    logic        four_bit_mode_reg;
    logic [7:0]  cursor_base_reg;
    logic [15:0] phase_ticks_reg;

    logic             step;
    clws_pkg::item_t  item;
    clws_pkg::seq_cfg_t seq_cfg;
    clws_pkg::lines_t lines_next;
    logic             seq_accepted;
    logic [7:0]       cursor_addr;

    logic             m_valid_reg, m_valid_next;
    clws_pkg::lines_t lines_reg;
    logic             accepted_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_bit_mode_reg <= clws_pkg::FOUR_BIT_MODE_RST;
            cursor_base_reg   <= clws_pkg::CURSOR_BASE_RST;
            phase_ticks_reg   <= clws_pkg::PHASE_TICKS_RST;
        end else if (cfg_write_enable) begin
            case (cfg_index)
                clws_pkg::CFG_FOUR_BIT_MODE: four_bit_mode_reg <= cfg_write_data[0];
                clws_pkg::CFG_CURSOR_BASE:   cursor_base_reg   <= cfg_write_data[7:0];
                clws_pkg::CFG_PHASE_TICKS:   phase_ticks_reg   <= cfg_write_data[15:0];
                default: ;
            endcase
        end
    end

    // Request decode, including cursor address
    assign step        = s_valid && s_ready;
    assign cursor_addr = (s_column + clws_pkg::row_offset(s_row[1:0])) | cursor_base_reg;

    always_comb begin
        item.is_tick     = (s_operation == clws_pkg::OP_TICK);
        item.busy_line   = s_busy_line;
        item.req_is_data = (s_operation == clws_pkg::OP_WRITE_CHAR);
        case (s_operation)
            clws_pkg::OP_WRITE_CMD, clws_pkg::OP_WRITE_CHAR: begin
                item.req_valid = 1'b1;
                item.req_byte  = s_value;
            end
            clws_pkg::OP_SET_CURSOR: begin
                item.req_valid = !s_row[2];
                item.req_byte  = cursor_addr;
            end
            default: begin
                item.req_valid = 1'b0;
                item.req_byte  = s_value;
            end
        endcase
        seq_cfg.four_bit_mode = four_bit_mode_reg;
        seq_cfg.phase_ticks   = phase_ticks_reg;
    end

    clws_seq #(
        .PHASE_COUNT_WIDTH(PHASE_COUNT_WIDTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (item),
        .cfg        (seq_cfg),
        .lines_next (lines_next),
        .accepted   (seq_accepted)
    );

    // Result register
    assign s_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            lines_reg    <= lines_next;
            accepted_reg <= seq_accepted;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rs_line     = lines_reg.rs;
    assign m_rw_line     = lines_reg.rw;
    assign m_enable_line = lines_reg.e;
    assign m_data_lines  = lines_reg.data;
    assign m_data_drive  = lines_reg.drive;
    assign m_idle        = lines_reg.idle;
    assign m_accepted    = accepted_reg;

    // A stalled result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // Every accepted item shows up as a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("result lost");

    // Ticks are never reported as taken requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && s_operation == clws_pkg::OP_TICK |=> !m_accepted)
        else $error("tick marked accepted");

endmodule
